### hw/rtl/mexs_pkg.sv
`default_nettype none

package mexs_pkg;

  localparam int unsigned RegW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned FuncW  = 4;
  localparam int unsigned SelW   = 2;
  localparam int unsigned ShamtW = 5;

  localparam int unsigned LuiShift = 16;
  localparam int unsigned ShamtPos = 6;

  localparam logic [FuncW-1:0] FUNC_ADD  = 4'd0;
  localparam logic [FuncW-1:0] FUNC_SUB  = 4'd1;
  localparam logic [FuncW-1:0] FUNC_AND  = 4'd2;
  localparam logic [FuncW-1:0] FUNC_OR   = 4'd3;
  localparam logic [FuncW-1:0] FUNC_SLL  = 4'd4;
  localparam logic [FuncW-1:0] FUNC_SRL  = 4'd5;
  localparam logic [FuncW-1:0] FUNC_NOR  = 4'd7;
  localparam logic [FuncW-1:0] FUNC_SLTU = 4'd8;
  localparam logic [FuncW-1:0] FUNC_LUI  = 4'd10;
  localparam logic [FuncW-1:0] FUNC_EQ   = 4'd11;

  localparam logic [SelW-1:0] FWD_RF    = 2'd0;
  localparam logic [SelW-1:0] FWD_EXMEM = 2'd1;
  localparam logic [SelW-1:0] FWD_MEMWB = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [RegW-1:0]  src_a_reg;
    logic [RegW-1:0]  src_b_reg;
    logic [RegW-1:0]  rd_reg;
    logic [DataW-1:0] value_a;
    logic [DataW-1:0] value_b;
    logic [DataW-1:0] imm;
    logic             use_imm;
    logic             dest_is_rd;
    logic             writes_reg;
    logic             loads_mem;
    logic [DataW-1:0] mem_read_data;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] alu_result;
    logic             zero_flag;
    logic [DataW-1:0] store_data;
    logic [RegW-1:0]  dest_reg;
    logic [SelW-1:0]  forward_a_sel;
    logic [SelW-1:0]  forward_b_sel;
  } rsp_t;

  typedef struct packed {
    logic             exmem_writes;
    logic [RegW-1:0]  exmem_dest;
    logic             exmem_loads;
    logic [DataW-1:0] exmem_value;
    logic             memwb_writes;
    logic [RegW-1:0]  memwb_dest;
    logic             memwb_loads;
    logic [DataW-1:0] memwb_alu_value;
    logic [DataW-1:0] memwb_mem_value;
  } latch_t;

  typedef struct packed {
    logic [SelW-1:0]  sel_a;
    logic [SelW-1:0]  sel_b;
    logic [DataW-1:0] opa;
    logic [DataW-1:0] fwd_b;
  } fwd_t;

endpackage

`default_nettype wire

### hw/rtl/mexs_fwd.sv
`default_nettype none

module mexs_fwd (
  input  mexs_pkg::req_t   req,
  input  mexs_pkg::latch_t latch,
  output mexs_pkg::fwd_t   fwd
);

  logic exmem_hit_a;
  logic exmem_hit_b;
  logic memwb_hit_a;
  logic memwb_hit_b;
  logic [mexs_pkg::DataW-1:0] memwb_data;

  always_comb begin
    exmem_hit_a = latch.exmem_writes && (latch.exmem_dest != '0)
                  && (latch.exmem_dest == req.src_a_reg);
    exmem_hit_b = latch.exmem_writes && (latch.exmem_dest != '0)
                  && (latch.exmem_dest == req.src_b_reg);
    memwb_hit_a = latch.memwb_writes && (latch.memwb_dest != '0)
                  && (latch.memwb_dest == req.src_a_reg);
    memwb_hit_b = latch.memwb_writes && (latch.memwb_dest != '0)
                  && (latch.memwb_dest == req.src_b_reg);
    memwb_data  = latch.memwb_loads ? latch.memwb_mem_value : latch.memwb_alu_value;

    if (exmem_hit_a) begin
      fwd.sel_a = mexs_pkg::FWD_EXMEM;
      fwd.opa   = latch.exmem_value;
    end else if (memwb_hit_a) begin
      fwd.sel_a = mexs_pkg::FWD_MEMWB;
      fwd.opa   = memwb_data;
    end else begin
      fwd.sel_a = mexs_pkg::FWD_RF;
      fwd.opa   = req.value_a;
    end

    if (exmem_hit_b) begin
      fwd.sel_b = mexs_pkg::FWD_EXMEM;
      fwd.fwd_b = latch.exmem_value;
    end else if (memwb_hit_b) begin
      fwd.sel_b = mexs_pkg::FWD_MEMWB;
      fwd.fwd_b = memwb_data;
    end else begin
      fwd.sel_b = mexs_pkg::FWD_RF;
      fwd.fwd_b = req.value_b;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mexs_alu.sv
`default_nettype none

module mexs_alu (
  input  logic [mexs_pkg::FuncW-1:0]  func,
  input  logic [mexs_pkg::DataW-1:0]  opa,
  input  logic [mexs_pkg::DataW-1:0]  opb,
  input  logic [mexs_pkg::ShamtW-1:0] shamt,
  output logic [mexs_pkg::DataW-1:0]  result
);

  always_comb begin
    unique case (func)
      mexs_pkg::FUNC_ADD:  result = opa + opb;
      mexs_pkg::FUNC_SUB:  result = opa - opb;
      mexs_pkg::FUNC_AND:  result = opa & opb;
      mexs_pkg::FUNC_OR:   result = opa | opb;
      mexs_pkg::FUNC_SLL:  result = opb << shamt;
      mexs_pkg::FUNC_SRL:  result = opb >> shamt;
      mexs_pkg::FUNC_NOR:  result = ~(opa | opb);
      mexs_pkg::FUNC_SLTU: result = {{(mexs_pkg::DataW-1){1'b0}}, (opa < opb)};
      mexs_pkg::FUNC_LUI:  result = opb << mexs_pkg::LuiShift;
      mexs_pkg::FUNC_EQ:   result = {{(mexs_pkg::DataW-1){1'b0}}, (opa == opb)};
      default:             result = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/mips_execute_stage_with_forwarding.sv
// path: an accepted request is held in the input register, and its result is then registered onto rsp
// throughput: one request per cycle unless rsp_stall holds the output; forwarding, alu and latch
// shift are combinational between the input register and the result register
// reset: synchronous, clears both valid flags and the ex/mem and mem/wb latches to zero
`default_nettype none

module mips_execute_stage_with_forwarding (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mexs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mexs_pkg::rsp_t rsp
);

  logic             in_valid;
  mexs_pkg::req_t   in_req;
  mexs_pkg::latch_t latch;
  mexs_pkg::latch_t latch_next;
  mexs_pkg::fwd_t   fwd;
  mexs_pkg::rsp_t   rsp_next;
  logic             adv;
  logic [mexs_pkg::DataW-1:0]  opb;
  logic [mexs_pkg::ShamtW-1:0] shamt;
  logic [mexs_pkg::DataW-1:0]  result;

  assign adv       = in_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = in_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!req_stall) begin
      in_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_req <= req;
    end
  end

  mexs_fwd u_fwd (
    .req   (in_req),
    .latch (latch),
    .fwd   (fwd)
  );

  assign opb   = in_req.use_imm ? in_req.imm : fwd.fwd_b;
  assign shamt = in_req.imm[mexs_pkg::ShamtPos +: mexs_pkg::ShamtW];

  mexs_alu u_alu (
    .func   (in_req.func),
    .opa    (fwd.opa),
    .opb    (opb),
    .shamt  (shamt),
    .result (result)
  );

  always_comb begin
    rsp_next.alu_result    = result;
    rsp_next.zero_flag     = (result == '0);
    rsp_next.store_data    = fwd.fwd_b;
    rsp_next.dest_reg      = in_req.dest_is_rd ? in_req.rd_reg : in_req.src_b_reg;
    rsp_next.forward_a_sel = fwd.sel_a;
    rsp_next.forward_b_sel = fwd.sel_b;

    latch_next.memwb_writes    = latch.exmem_writes;
    latch_next.memwb_dest      = latch.exmem_dest;
    latch_next.memwb_loads     = latch.exmem_loads;
    latch_next.memwb_alu_value = latch.exmem_value;
    latch_next.memwb_mem_value = in_req.mem_read_data;
    latch_next.exmem_writes    = in_req.writes_reg;
    latch_next.exmem_dest      = rsp_next.dest_reg;
    latch_next.exmem_loads     = in_req.loads_mem;
    latch_next.exmem_value     = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= '0;
    end else if (adv) begin
      latch <= latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  a_exmem_tracks_rsp: assert property (@(posedge clk) disable iff (rst)
    adv |=> (latch.exmem_value == rsp.alu_result) && (latch.exmem_dest == rsp.dest_reg))
    else $error("ex/mem latch differs from delivered result");

  a_latch_shift: assert property (@(posedge clk) disable iff (rst)
    adv |=> (latch.memwb_alu_value == $past(latch.exmem_value))
            && (latch.memwb_dest == $past(latch.exmem_dest)))
    else $error("mem/wb latch did not take old ex/mem contents");

  a_latch_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(latch))
    else $error("latches moved without an advancing request");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.zero_flag == (rsp.alu_result == '0)))
    else $error("zero flag inconsistent with result");

endmodule

`default_nettype wire

### tb/mexs_checker.sv
module mexs_checker
  import mexs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   exmem_fwds,
  output int   memwb_fwds
);

  timeunit 1ns;
  timeprecision 1ps;

  latch_t pipe;
  rsp_t   expected_q[$];

  function automatic logic [DataW-1:0] pick_operand(input logic [RegW-1:0] src,
                                                    input logic [DataW-1:0] rf_value,
                                                    output logic [SelW-1:0] sel);
    if (pipe.exmem_writes && pipe.exmem_dest != '0 && pipe.exmem_dest == src) begin
      sel = FWD_EXMEM;
      return pipe.exmem_value;
    end
    if (pipe.memwb_writes && pipe.memwb_dest != '0 && pipe.memwb_dest == src) begin
      sel = FWD_MEMWB;
      return pipe.memwb_loads ? pipe.memwb_mem_value : pipe.memwb_alu_value;
    end
    sel = FWD_RF;
    return rf_value;
  endfunction

  function automatic logic [DataW-1:0] alu_eval(input logic [FuncW-1:0] code,
                                                input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
    case (code)
      FUNC_ADD:  return a + b;
      FUNC_SUB:  return a - b;
      FUNC_AND:  return a & b;
      FUNC_OR:   return a | b;
      FUNC_SLL:  return b << a[ShamtW-1:0];
      FUNC_SRL:  return b >> a[ShamtW-1:0];
      FUNC_NOR:  return ~(a | b);
      FUNC_SLTU: return (a < b) ? DataW'(1) : '0;
      FUNC_LUI:  return b << LuiShift;
      FUNC_EQ:   return (a == b) ? DataW'(1) : '0;
      default:   return '0;
    endcase
  endfunction

  // computes the execute result and advances the ex/mem and mem/wb latches
  function automatic rsp_t execute_instr(input req_t r);
    rsp_t             o;
    logic [DataW-1:0] opa;
    logic [DataW-1:0] opb;
    logic [SelW-1:0]  sa;
    logic [SelW-1:0]  sb;
    opa = pick_operand(r.src_a_reg, r.value_a, sa);
    o.store_data = pick_operand(r.src_b_reg, r.value_b, sb);
    opb = r.use_imm ? r.imm : o.store_data;
    if (r.func == FUNC_SLL || r.func == FUNC_SRL) begin
      opa = DataW'(r.imm[ShamtPos +: ShamtW]);
    end
    o.alu_result    = alu_eval(r.func, opa, opb);
    o.zero_flag     = (o.alu_result == '0);
    o.dest_reg      = r.dest_is_rd ? r.rd_reg : r.src_b_reg;
    o.forward_a_sel = sa;
    o.forward_b_sel = sb;
    pipe.memwb_writes    = pipe.exmem_writes;
    pipe.memwb_dest      = pipe.exmem_dest;
    pipe.memwb_loads     = pipe.exmem_loads;
    pipe.memwb_alu_value = pipe.exmem_value;
    pipe.memwb_mem_value = r.mem_read_data;
    pipe.exmem_writes    = r.writes_reg;
    pipe.exmem_dest      = o.dest_reg;
    pipe.exmem_loads     = r.loads_mem;
    pipe.exmem_value     = o.alu_result;
    return o;
  endfunction

  task automatic report_field(input string name, input logic [DataW-1:0] want,
                              input logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    exmem_fwds = 0;
    memwb_fwds = 0;
  end

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      pipe = '0;
      expected_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual %p",
                   $time, rsp);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          report_field("alu_result", want.alu_result, rsp.alu_result);
          report_field("zero_flag", DataW'(want.zero_flag), DataW'(rsp.zero_flag));
          report_field("store_data", want.store_data, rsp.store_data);
          report_field("dest_reg", DataW'(want.dest_reg), DataW'(rsp.dest_reg));
          report_field("forward_a_sel", DataW'(want.forward_a_sel),
                       DataW'(rsp.forward_a_sel));
          report_field("forward_b_sel", DataW'(want.forward_b_sel),
                       DataW'(rsp.forward_b_sel));
          checked++;
        end
      end
      if (req_valid && !req_stall) begin
        want = execute_instr(req);
        if (want.forward_a_sel == FWD_EXMEM) exmem_fwds++;
        if (want.forward_b_sel == FWD_EXMEM) exmem_fwds++;
        if (want.forward_a_sel == FWD_MEMWB) memwb_fwds++;
        if (want.forward_b_sel == FWD_MEMWB) memwb_fwds++;
        expected_q.push_back(want);
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/tb_mips_execute_stage_with_forwarding.sv
module tb_mips_execute_stage_with_forwarding;

  timeunit 1ns;
  timeprecision 1ps;

  import mexs_pkg::*;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int fail_count;
  int pending;
  int checked;
  int exmem_fwds;
  int memwb_fwds;
  int sent;
  bit hold_off_go;

  mips_execute_stage_with_forwarding i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  mexs_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .exmem_fwds (exmem_fwds),
    .memwb_fwds (memwb_fwds)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_mips_execute_stage_with_forwarding: FAIL");
    $finish;
  end

  function automatic req_t mk_instr(input logic [FuncW-1:0] f, input logic [RegW-1:0] ra,
                                    input logic [RegW-1:0] rb, input logic [RegW-1:0] rd,
                                    input logic [DataW-1:0] va, input logic [DataW-1:0] vb,
                                    input logic [DataW-1:0] im, input logic ui,
                                    input logic drd, input logic wr, input logic ld);
    req_t r;
    r.func          = f;
    r.src_a_reg     = ra;
    r.src_b_reg     = rb;
    r.rd_reg        = rd;
    r.value_a       = va;
    r.value_b       = vb;
    r.imm           = im;
    r.use_imm       = ui;
    r.dest_is_rd    = drd;
    r.writes_reg    = wr;
    r.loads_mem     = ld;
    r.mem_read_data = $urandom;
    return r;
  endfunction

  // mostly a small register pool so that back-to-back hazards are common
  function automatic logic [RegW-1:0] rand_reg();
    if ($urandom_range(0, 3) != 0) return RegW'($urandom_range(0, 3));
    return RegW'($urandom_range(0, 31));
  endfunction

  function automatic req_t rand_instr();
    req_t             r;
    logic [15:0]      half;
    half            = 16'($urandom);
    r.func          = FuncW'($urandom_range(0, 15));
    r.src_a_reg     = rand_reg();
    r.src_b_reg     = rand_reg();
    r.rd_reg        = rand_reg();
    r.value_a       = $urandom;
    r.value_b       = $urandom;
    r.imm           = ($urandom_range(0, 3) != 0) ? {{16{half[15]}}, half} : $urandom;
    r.use_imm       = 1'($urandom_range(0, 1));
    r.dest_is_rd    = 1'($urandom_range(0, 1));
    r.writes_reg    = ($urandom_range(0, 4) != 0);
    r.loads_mem     = ($urandom_range(0, 2) == 0);
    r.mem_read_data = $urandom;
    return r;
  endfunction

  task automatic send_instr(input req_t r);
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic idle_for(input int unsigned cycles);
    req_valid <= 1'b0;
    req       <= rand_instr();
    repeat (cycles) @(posedge clk);
  endtask

  // receiver: random stall pattern, plus a long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned span;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 5);
      span = $urandom_range(4, 40);
      repeat (span) begin
        if (hold_off_go) begin
          hold_off_go = 1'b0;
          rsp_stall <= 1'b1;
          repeat (60) begin
            @(posedge clk);
            rsp_stall <= 1'b1;
          end
        end else begin
          case (mode)
            0, 1:    rsp_stall <= 1'b0;
            2:       rsp_stall <= ($urandom_range(0, 1) == 0);
            3:       rsp_stall <= ($urandom_range(0, 4) == 0);
            4:       rsp_stall <= ($urandom_range(0, 4) != 0);
            default: rsp_stall <= 1'b1;
          endcase
        end
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned burst;
    sent        = 0;
    hold_off_go = 1'b0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // forwarding paths, register zero, loads in both latches
    send_instr(mk_instr(FUNC_ADD, 0, 0, 1, 32'hFFFF_FFFF, 32'h1, 0, 0, 1, 1, 0));
    send_instr(mk_instr(FUNC_SUB, 1, 1, 2, 32'h7, 32'h9, 0, 0, 1, 1, 0));
    send_instr(mk_instr(FUNC_AND, 1, 2, 3, 32'h5, 32'h6, 0, 0, 1, 1, 0));
    send_instr(mk_instr(FUNC_OR, 3, 2, 0, 32'h0, 32'h0, 0, 0, 1, 1, 0));
    send_instr(mk_instr(FUNC_NOR, 0, 0, 9, 32'h0, 32'h0, 0, 0, 0, 1, 0));
    send_instr(mk_instr(FUNC_ADD, 0, 5, 4, 32'h0, 32'h0, 32'h0000_1000, 1, 0, 1, 1));
    send_instr(mk_instr(FUNC_SLTU, 5, 6, 6, 32'h0, 32'hFFFF_FFFF, 0, 0, 1, 1, 1));
    send_instr(mk_instr(FUNC_EQ, 5, 6, 7, 32'h0, 32'h0, 0, 0, 1, 1, 0));
    send_instr(mk_instr(FUNC_ADD, 0, 0, 7, 32'h3, 32'h4, 0, 0, 1, 1, 0));
    send_instr(mk_instr(FUNC_SRL, 7, 7, 8, 32'h0, 32'h0, 32'h0000_0040, 0, 1, 1, 0));
    send_instr(mk_instr(FUNC_LUI, 7, 7, 8, 32'h0, 32'h0, 32'hFFFF_ABCD, 1, 1, 0, 0));
    // every alu code with extreme operands and the largest shift amount
    for (int code = 0; code < 16; code++) begin
      send_instr(mk_instr(FuncW'(code), 31, 30, 31, 32'hFFFF_FFFF, 32'h8000_0000,
                          32'hFFFF_FFC0, 1'(code % 2), 1'(code / 8), 1'(code % 3 == 0),
                          1'(code % 4 == 1)));
    end

    // let everything drain before loading up the pipe
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    hold_off_go = 1'b1;
    repeat (40) send_instr(rand_instr());

    while (sent < 1500) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_instr(rand_instr());
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
      if ($urandom_range(0, 40) == 0) hold_off_go = 1'b1;
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d instructions, checked %0d results", sent, checked);
    $display("operands forwarded: %0d from ex/mem, %0d from mem/wb", exmem_fwds, memwb_fwds);
    if (fail_count == 0) begin
      $display("tb_mips_execute_stage_with_forwarding: PASS");
    end else begin
      $display("tb_mips_execute_stage_with_forwarding: FAIL");
    end
    $finish;
  end

endmodule
